// File: rtl/core/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared sizes, constants, command and status structs and the digit-to-ASCII mapping
// for the integer to ASCII radix converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

    localparam int VALUE_BITS = 32;
    localparam int MAX_DIGITS = 32;

    // Quotient bits resolved per divider cycle. VALUE_BITS must be a multiple.
    localparam int BITS_PER_CYCLE = 4;
    localparam int DIV_CYCLES     = VALUE_BITS / BITS_PER_CYCLE;
    localparam int STEP_W         = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam int RADIX_W = 6;
    localparam int CHAR_W  = 8;
    localparam int ADDR_W  = $clog2(MAX_DIGITS);
    localparam int COUNT_W = $clog2(MAX_DIGITS + 1);

    localparam logic [RADIX_W-1:0] RADIX_MIN   = RADIX_W'(2);
    localparam logic [RADIX_W-1:0] RADIX_MAX   = RADIX_W'(36);
    localparam logic [RADIX_W-1:0] RADIX_TEN   = RADIX_W'(10);
    localparam logic [RADIX_W-1:0] DIGIT_NINE  = RADIX_W'(9);

    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

    typedef struct packed {
        logic start;       // load a new request
        logic div_step;    // one divider iteration
        logic digit_done;  // last iteration of a digit: store it
        logic rd_en;       // read the digit store
        logic load_sign;   // put '-' in the output register
        logic load_digit;  // put the read digit in the output register
    } t_cmd;

    typedef struct packed {
        logic quot_zero;   // quotient after this iteration is zero
        logic store_full;  // the digit being stored fills the store
        logic sign;        // a minus sign is pending
        logic last_digit;  // the digit being emitted is the last one
        logic out_free;    // output register can take a character
    } t_stat;

    function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
        if (d > DIGIT_NINE) begin
            return CHAR_A + CHAR_W'(d) - CHAR_W'(10);
        end
        return CHAR_ZERO + CHAR_W'(d);
    endfunction

endpackage

// File: rtl/core/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// Operation: a request is accepted in S_IDLE, then each digit is divided out
// (4 quotient bits per cycle over 32 bits), then an optional minus sign goes
// out and each digit is read from the store and loaded into the output register.
// Throughput: one request at a time; a new request is taken only once the
// last character of the previous one has been loaded into the output register.
// Reset: synchronous, active low; the radix returns to 10, the output is empty.
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a 32-bit integer to ASCII text in a programmable radix, one
// character per output request, most significant digit first.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]           i_cfg_wdata,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [itoa_pkg::VALUE_BITS-1:0] i_number,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic [itoa_pkg::CHAR_W-1:0]            o_character,
    output logic                                   o_final_char
);

    // The controller steps the divider until the quotient runs out or the digit
    // store is full, storing one digit (least significant first) per division. It
    // then emits an optional minus sign and reads the digits back in reverse order.
    itoa_pkg::t_cmd  cmd;
    itoa_pkg::t_stat stat;

    itoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // The datapath holds the clamped radix, the shift-subtract divider, the
    // digit store and the output register that decouples the output side.
    itoa_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_number     (i_number),
        .i_ready      (i_ready),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_character  (o_character),
        .o_final_char (o_final_char)
    );

    // A character is only loaded when the output register can take it.
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_sign || cmd.load_digit) |-> stat.out_free)
        else $error("character loaded over an untaken output");

    // Once a request is accepted, no second one is accepted next cycle.
    a_one_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("request accepted while busy");

    // Start, division and loads are mutually exclusive commands.
    a_cmd_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.div_step, cmd.load_sign, cmd.load_digit, cmd.rd_en}))
        else $error("conflicting datapath commands");

endmodule

// File: rtl/core/itoa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module itoa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/itoa_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: radix register, shift-subtract divider, digit store and the
// output register.
// ----------------------------------------------------------------------------
module itoa_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [itoa_pkg::RADIX_W-1:0]           i_cfg_wdata,
    input  logic signed [itoa_pkg::VALUE_BITS-1:0] i_number,
    input  logic                                   i_ready,
    input  itoa_pkg::t_cmd                         i_cmd,
    output itoa_pkg::t_stat                        o_stat,
    output logic                                   o_valid,
    output logic [itoa_pkg::CHAR_W-1:0]            o_character,
    output logic                                   o_final_char
);

    localparam int VB  = itoa_pkg::VALUE_BITS;
    localparam int BPC = itoa_pkg::BITS_PER_CYCLE;
    localparam int RW  = itoa_pkg::RADIX_W;

    logic [RW-1:0]                    r_radix, n_radix;
    logic [VB-1:0]                    r_work, n_work;
    logic [RW-1:0]                    r_rem, n_rem;
    logic [itoa_pkg::COUNT_W-1:0]     r_count, n_count;
    logic                             r_sign, n_sign;
    logic                             r_out_valid, n_out_valid;
    logic [itoa_pkg::CHAR_W-1:0]      r_char, n_char;
    logic                             r_final, n_final;

    logic [RW:0]                      div_trial;
    logic [RW-1:0]                    div_rem;
    logic [BPC-1:0]                   div_q;
    logic [VB-1:0]                    div_work;
    logic                             in_neg;
    logic [RW-1:0]                    rd_digit;
    logic [itoa_pkg::COUNT_W-1:0]     count_m1;
    logic                             out_free;

    // Restoring division, BPC quotient bits per cycle. The dividend bits leave
    // the top of r_work while the quotient bits enter at the bottom.
    always_comb begin
        div_rem   = r_rem;
        div_trial = '0;
        div_q     = '0;
        for (int k = 0; k < BPC; k++) begin
            div_trial = {div_rem, r_work[VB-1-k]};
            if (div_trial >= {1'b0, r_radix}) begin
                div_rem          = RW'(div_trial - {1'b0, r_radix});
                div_q[BPC-1-k]   = 1'b1;
            end else begin
                div_rem          = div_trial[RW-1:0];
            end
        end
        div_work = {r_work[VB-BPC-1:0], div_q};
    end

    assign in_neg   = (r_radix == itoa_pkg::RADIX_TEN) && i_number[VB-1];
    assign count_m1 = r_count - itoa_pkg::COUNT_W'(1);
    assign out_free = !r_out_valid || i_ready;

    always_comb begin
        n_radix     = r_radix;
        n_work      = r_work;
        n_rem       = r_rem;
        n_count     = r_count;
        n_sign      = r_sign;
        n_out_valid = r_out_valid;
        n_char      = r_char;
        n_final     = r_final;

        if (i_cfg_we) begin
            if (i_cfg_wdata < itoa_pkg::RADIX_MIN) begin
                n_radix = itoa_pkg::RADIX_MIN;
            end else if (i_cfg_wdata > itoa_pkg::RADIX_MAX) begin
                n_radix = itoa_pkg::RADIX_MAX;
            end else begin
                n_radix = i_cfg_wdata;
            end
        end

        if (i_cmd.start) begin
            n_work  = in_neg ? (VB'(0) - VB'(i_number)) : VB'(i_number);
            n_rem   = '0;
            n_count = '0;
            n_sign  = in_neg;
        end else if (i_cmd.div_step) begin
            n_work = div_work;
            n_rem  = div_rem;
            if (i_cmd.digit_done) begin
                n_rem   = '0;
                n_count = r_count + itoa_pkg::COUNT_W'(1);
            end
        end

        if (out_free) begin
            n_out_valid = 1'b0;
        end
        if (i_cmd.load_sign) begin
            n_out_valid = 1'b1;
            n_char      = itoa_pkg::CHAR_MINUS;
            n_final     = 1'b0;
            n_sign      = 1'b0;
        end else if (i_cmd.load_digit) begin
            n_out_valid = 1'b1;
            n_char      = itoa_pkg::digit_to_ascii(rd_digit);
            n_final     = (r_count == itoa_pkg::COUNT_W'(1));
            n_count     = count_m1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix     <= itoa_pkg::RADIX_TEN;
            r_count     <= '0;
            r_sign      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_radix     <= n_radix;
            r_count     <= n_count;
            r_sign      <= n_sign;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work  <= n_work;
        r_rem   <= n_rem;
        r_char  <= n_char;
        r_final <= n_final;
    end

    itoa_ram #(
        .WIDTH (RW),
        .DEPTH (itoa_pkg::MAX_DIGITS)
    ) u_digit_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.digit_done),
        .i_waddr (r_count[itoa_pkg::ADDR_W-1:0]),
        .i_wdata (div_rem),
        .i_re    (i_cmd.rd_en),
        .i_raddr (count_m1[itoa_pkg::ADDR_W-1:0]),
        .o_rdata (rd_digit)
    );

    assign o_stat.quot_zero  = (div_work == '0);
    assign o_stat.store_full =
        (r_count == itoa_pkg::COUNT_W'(itoa_pkg::MAX_DIGITS - 1));
    assign o_stat.sign       = r_sign;
    assign o_stat.last_digit = (r_count == itoa_pkg::COUNT_W'(1));
    assign o_stat.out_free   = out_free;

    assign o_valid      = r_out_valid;
    assign o_character  = r_char;
    assign o_final_char = r_final;

endmodule

// File: rtl/core/itoa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_ctrl
// Controller: sequences digit extraction and most-significant-first emission.
// ----------------------------------------------------------------------------
module itoa_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  itoa_pkg::t_stat i_stat,
    output itoa_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIV  = 3'd1;
    localparam logic [2:0] S_SIGN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_LOAD = 3'd4;

    localparam logic [itoa_pkg::STEP_W-1:0] STEP_LAST =
        itoa_pkg::STEP_W'(itoa_pkg::DIV_CYCLES - 1);

    logic [2:0]                  r_state, n_state;
    logic [itoa_pkg::STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.start = 1'b1;
                    n_step      = '0;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_step         = r_step + itoa_pkg::STEP_W'(1);
                if (r_step == STEP_LAST) begin
                    o_cmd.digit_done = 1'b1;
                    n_step           = '0;
                    if (i_stat.quot_zero || i_stat.store_full) begin
                        n_state = i_stat.sign ? S_SIGN : S_READ;
                    end
                end
            end
            S_SIGN: begin
                if (i_stat.out_free) begin
                    o_cmd.load_sign = 1'b1;
                    n_state         = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                if (i_stat.out_free) begin
                    o_cmd.load_digit = 1'b1;
                    n_state          = i_stat.last_digit ? S_IDLE : S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

endmodule
